### src/assert_macros.svh
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rid_pkg.sv
`timescale 1ns / 1ps
package rid_pkg;

  // Fixed field widths of the transaction ports
  localparam int FUNC_W = 3;
  localparam int POS_W  = 10;
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 11;
  localparam int STAT_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_L  = 3'd0,
    FUNC_PUSH_R  = 3'd1,
    FUNC_POP_L   = 3'd2,
    FUNC_POP_R   = 3'd3,
    FUNC_READ    = 3'd4,
    FUNC_WRITE   = 3'd5,
    FUNC_REVERSE = 3'd6,
    FUNC_NOP     = 3'd7
  } rid_func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_POP_EMPTY = 2'd1,
    STAT_PUSH_FULL = 2'd2,
    STAT_RANGE     = 2'd3
  } rid_status_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_ENDS = 2'd1,
    FSM_LOAD = 2'd2
  } rid_fsm_t;

  // Control handed from the sequencer to the result register
  typedef struct packed {
    logic              capture_read;
    logic              read_ok;
    logic              load;
    rid_status_t       status;
    logic [CNT_W-1:0]  count;
    logic              empty;
    logic              reversed;
  } rid_load_t;

endpackage

### src/reversible_indexed_deque.sv
`timescale 1ns / 1ps
// Reversible indexed deque: a ring buffer of DEPTH entries that takes one operation per
// transaction (push or pop at either end, read or write by logical index, or reverse) and
// returns one result with status, read data, count, empty flag and both end values.
// Each operation passes an accept step, which does the memory write or indexed read, an
// end-fetch step, which fetches both ring ends through the two read ports of the element
// memory, and a load step, which loads the result register and so offers the result. A
// new operation is accepted as soon as the previous one has been loaded, even if that
// result has not yet been taken; a held result stalls only the load step. The element
// memory needs no initialization after reset: only entries written by a push or a write
// are ever reported.
module reversible_indexed_deque #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rid_pkg::FUNC_W-1:0]       in_func,
  input  logic [rid_pkg::POS_W-1:0]        in_position,
  input  logic signed [rid_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rid_pkg::STAT_W-1:0]       out_status,
  output logic signed [rid_pkg::VAL_W-1:0] out_read_data,
  output logic [rid_pkg::CNT_W-1:0]        out_count,
  output logic                             out_is_empty,
  output logic signed [rid_pkg::VAL_W-1:0] out_left_value,
  output logic signed [rid_pkg::VAL_W-1:0] out_right_value
);
  import rid_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic signed [DATA_WIDTH-1:0] wr_data;
  logic                         rd_a_en;
  logic [AW-1:0]                rd_a_addr;
  logic signed [DATA_WIDTH-1:0] rd_a_data;
  logic                         rd_b_en;
  logic [AW-1:0]                rd_b_addr;
  logic signed [DATA_WIDTH-1:0] rd_b_data;
  rid_load_t                    ld;
  logic                         out_free;

  logic                         out_valid_r;
  logic [STAT_W-1:0]            out_status_r;
  logic signed [VAL_W-1:0]      out_read_data_r;
  logic [CNT_W-1:0]             out_count_r;
  logic                         out_is_empty_r;
  logic signed [VAL_W-1:0]      out_left_r;
  logic signed [VAL_W-1:0]      out_right_r;
  logic signed [VAL_W-1:0]      rd_hold_r;
  logic signed [VAL_W-1:0]      first_val;
  logic signed [VAL_W-1:0]      last_val;

  rid_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_func),
    .in_position (in_position),
    .in_value    (in_value),
    .out_free    (out_free),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_a_en     (rd_a_en),
    .rd_a_addr   (rd_a_addr),
    .rd_b_en     (rd_b_en),
    .rd_b_addr   (rd_b_addr),
    .ld          (ld)
  );

  rid_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_en   (rd_a_en),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_en   (rd_b_en),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_data)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign first_val = VAL_W'(rd_a_data);
  assign last_val  = VAL_W'(rd_b_data);

  // Keep the indexed read before port A is reused for the ends
  always_ff @(posedge clk) begin
    if (ld.capture_read) begin
      rd_hold_r <= ld.read_ok ? first_val : '0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (ld.load) begin
      out_status_r    <= ld.status;
      out_read_data_r <= rd_hold_r;
      out_count_r     <= ld.count;
      out_is_empty_r  <= ld.empty;
      if (ld.empty) begin
        out_left_r  <= '0;
        out_right_r <= '0;
      end else if (ld.reversed) begin
        out_left_r  <= last_val;
        out_right_r <= first_val;
      end else begin
        out_left_r  <= first_val;
        out_right_r <= last_val;
      end
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_data   = out_read_data_r;
  assign out_count       = out_count_r;
  assign out_is_empty    = out_is_empty_r;
  assign out_left_value  = out_left_r;
  assign out_right_value = out_right_r;

endmodule

### src/rid_mem.sv
`timescale 1ns / 1ps
module rid_mem #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic signed [DATA_WIDTH-1:0]  wr_data,
  input  logic                          rd_a_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_a_addr,
  output logic signed [DATA_WIDTH-1:0]  rd_a_data,
  input  logic                          rd_b_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_b_addr,
  output logic signed [DATA_WIDTH-1:0]  rd_b_data
);

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port A, data holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_a_en) begin
      rd_a_data <= mem[rd_a_addr];
    end
  end

  // Read port B, data holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_b_en) begin
      rd_b_data <= mem[rd_b_addr];
    end
  end

endmodule

### src/rid_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rid_ctrl #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rid_pkg::FUNC_W-1:0]      in_func,
  input  logic [rid_pkg::POS_W-1:0]       in_position,
  input  logic signed [rid_pkg::VAL_W-1:0] in_value,
  input  logic                            out_free,
  output logic                            wr_en,
  output logic [$clog2(DEPTH)-1:0]        wr_addr,
  output logic signed [DATA_WIDTH-1:0]    wr_data,
  output logic                            rd_a_en,
  output logic [$clog2(DEPTH)-1:0]        rd_a_addr,
  output logic                            rd_b_en,
  output logic [$clog2(DEPTH)-1:0]        rd_b_addr,
  output rid_pkg::rid_load_t              ld
);
  import rid_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // Ring slot of a physical offset from the front, modulo DEPTH
  function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  rid_fsm_t    state_r, state_nxt;
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic        rev_r, rev_nxt;
  rid_status_t status_r, status_nxt;
  logic        read_ok_r, read_ok_nxt;

  logic        accept;
  logic        ends_rd;
  logic        load;
  rid_func_t   func;
  logic        full;
  logic        empty;
  logic        in_range;
  logic        phys_right;
  logic [AW-1:0] pos_a;
  logic [AW-1:0] cnt_m1;
  logic [AW-1:0] phys;
  logic [AW-1:0] pos_slot;
  logic [AW-1:0] tail_slot;
  logic [AW-1:0] last_slot;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;

  assign accept = in_valid && in_ready;
  assign func   = rid_func_t'(in_func);

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (in_valid) begin
          state_nxt = FSM_ENDS;
        end
      end
      FSM_ENDS: state_nxt = FSM_LOAD;
      FSM_LOAD: begin
        if (out_free) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    ends_rd  = 1'b0;
    load     = 1'b0;
    unique case (state_r)
      FSM_IDLE: in_ready = 1'b1;
      FSM_ENDS: ends_rd  = 1'b1;
      FSM_LOAD: load     = out_free;
      default: ;
    endcase
  end

  // Address arithmetic on the ring
  assign full       = (count_r == CW'(DEPTH));
  assign empty      = (count_r == '0);
  assign in_range   = (CMPW'(in_position) < CMPW'(count_r));
  assign phys_right = ((func == FUNC_PUSH_R) || (func == FUNC_POP_R)) ^ rev_r;
  assign pos_a      = AW'(in_position);
  assign cnt_m1     = AW'(count_r - CW'(1));
  assign phys       = rev_r ? (cnt_m1 - pos_a) : pos_a;
  assign pos_slot   = add_mod(front_r, phys);
  assign tail_slot  = add_mod(front_r, AW'(count_r));
  assign last_slot  = add_mod(front_r, cnt_m1);
  assign front_dec  = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign front_inc  = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);

  // Decode the transaction, update pointers and drive the memory ports
  always_comb begin
    front_nxt   = front_r;
    count_nxt   = count_r;
    rev_nxt     = rev_r;
    status_nxt  = status_r;
    read_ok_nxt = read_ok_r;
    wr_en       = 1'b0;
    wr_addr     = pos_slot;
    wr_data     = DATA_WIDTH'(in_value);
    rd_a_en     = 1'b0;
    rd_a_addr   = pos_slot;
    rd_b_en     = 1'b0;
    rd_b_addr   = last_slot;
    if (accept) begin
      status_nxt  = STAT_OK;
      read_ok_nxt = 1'b0;
      case (func)
        FUNC_PUSH_L, FUNC_PUSH_R: begin
          if (full) begin
            status_nxt = STAT_PUSH_FULL;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
            if (phys_right) begin
              wr_addr = tail_slot;
            end else begin
              wr_addr   = front_dec;
              front_nxt = front_dec;
            end
          end
        end
        FUNC_POP_L, FUNC_POP_R: begin
          if (empty) begin
            status_nxt = STAT_POP_EMPTY;
          end else begin
            count_nxt = count_r - CW'(1);
            if (!phys_right) begin
              front_nxt = front_inc;
            end
          end
        end
        FUNC_READ: begin
          if (!in_range) begin
            status_nxt = STAT_RANGE;
          end else begin
            rd_a_en     = 1'b1;
            read_ok_nxt = 1'b1;
          end
        end
        FUNC_WRITE: begin
          if (!in_range) begin
            status_nxt = STAT_RANGE;
          end else begin
            wr_en = 1'b1;
          end
        end
        FUNC_REVERSE: rev_nxt = !rev_r;
        default: ;
      endcase
    end else if (ends_rd) begin
      // Fetch both physical ends with the updated pointers
      rd_a_en   = 1'b1;
      rd_a_addr = front_r;
      rd_b_en   = 1'b1;
    end
  end

  // Hand off to the result register
  always_comb begin
    ld.capture_read = ends_rd;
    ld.read_ok      = read_ok_r;
    ld.load         = load;
    ld.status       = status_r;
    ld.count        = CNT_W'(count_r);
    ld.empty        = empty;
    ld.reversed     = rev_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= FSM_IDLE;
      front_r   <= '0;
      count_r   <= '0;
      rev_r     <= 1'b0;
      status_r  <= STAT_OK;
      read_ok_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      front_r   <= front_nxt;
      count_r   <= count_nxt;
      rev_r     <= rev_nxt;
      status_r  <= status_nxt;
      read_ok_r <= read_ok_nxt;
    end
  end

  `ASSERT_HOLD(a_count_bound, count_r <= CW'(DEPTH), "element count exceeds depth")
  `ASSERT_NEXT(a_accept_ends, accept, state_r == FSM_ENDS, "end fetch does not follow accept")
  `ASSERT_NEXT(a_state_quiet, !accept,
               $stable(count_r) && $stable(front_r) && $stable(rev_r),
               "ring state changed without a transaction")
  `ASSERT_IMPL(a_write_idle, wr_en, accept && !ends_rd, "memory write outside accept")

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import rid_pkg::*;

  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 32;

  typedef struct {
    rid_func_t        func;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } deque_op_t;

  typedef struct {
    rid_status_t      status;
    logic [VAL_W-1:0] read_data;
    logic [CNT_W-1:0] count;
    logic             is_empty;
    logic [VAL_W-1:0] left_value;
    logic [VAL_W-1:0] right_value;
  } deque_view_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [FUNC_W-1:0]       in_func = '0;
  logic [POS_W-1:0]        in_position = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [STAT_W-1:0]       out_status;
  logic signed [VAL_W-1:0] out_read_data;
  logic [CNT_W-1:0]        out_count;
  logic                    out_is_empty;
  logic signed [VAL_W-1:0] out_left_value;
  logic signed [VAL_W-1:0] out_right_value;

  deque_op_t   pending_ops[$];
  deque_view_t due_views[$];
  int          ops_accepted = 0;
  int          ops_total = 0;
  int          error_count = 0;
  int          gen_count = 0;
  logic        in_taken = 1'b0;
  logic        hold_off = 1'b0;

  // Shadow deque state
  logic [VAL_W-1:0] shadow_mem [DEPTH];
  logic [POS_W-1:0] shadow_front = '0;
  logic [CNT_W-1:0] shadow_held = '0;
  logic             shadow_flipped = 1'b0;

  reversible_indexed_deque #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_position(in_position),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_read_data(out_read_data),
    .out_count(out_count),
    .out_is_empty(out_is_empty),
    .out_left_value(out_left_value),
    .out_right_value(out_right_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one operation to the shadow deque and return the view it reports
  function automatic deque_view_t predict_deque_view(deque_op_t op);
    deque_view_t v;
    logic        at_right;
    logic [CNT_W-1:0] phys;
    logic [POS_W-1:0] slot;
    logic [POS_W-1:0] first;
    logic [POS_W-1:0] last;
    v.status    = STAT_OK;
    v.read_data = '0;
    case (op.func)
      FUNC_PUSH_L, FUNC_PUSH_R: begin
        if (shadow_held == DEPTH) begin
          v.status = STAT_PUSH_FULL;
        end else begin
          at_right = (op.func == FUNC_PUSH_R) ^ shadow_flipped;
          if (at_right) begin
            slot = shadow_front + shadow_held[POS_W-1:0];
            shadow_mem[slot] = op.value;
          end else begin
            shadow_front = shadow_front - 1'b1;
            shadow_mem[shadow_front] = op.value;
          end
          shadow_held = shadow_held + 1'b1;
        end
      end
      FUNC_POP_L, FUNC_POP_R: begin
        if (shadow_held == 0) begin
          v.status = STAT_POP_EMPTY;
        end else begin
          at_right = (op.func == FUNC_POP_R) ^ shadow_flipped;
          if (!at_right) shadow_front = shadow_front + 1'b1;
          shadow_held = shadow_held - 1'b1;
        end
      end
      FUNC_READ, FUNC_WRITE: begin
        if (CNT_W'(op.position) >= shadow_held) begin
          v.status = STAT_RANGE;
        end else begin
          phys = shadow_flipped ? shadow_held - 1'b1 - CNT_W'(op.position)
                                : CNT_W'(op.position);
          slot = shadow_front + phys[POS_W-1:0];
          if (op.func == FUNC_READ) v.read_data = shadow_mem[slot];
          else shadow_mem[slot] = op.value;
        end
      end
      FUNC_REVERSE: shadow_flipped = !shadow_flipped;
      default: ;
    endcase
    v.count    = shadow_held;
    v.is_empty = (shadow_held == 0);
    if (shadow_held == 0) begin
      v.left_value  = '0;
      v.right_value = '0;
    end else begin
      first = shadow_front;
      last  = shadow_front + shadow_held[POS_W-1:0] - 1'b1;
      v.left_value  = shadow_flipped ? shadow_mem[last] : shadow_mem[first];
      v.right_value = shadow_flipped ? shadow_mem[first] : shadow_mem[last];
    end
    return v;
  endfunction

  // Queue one operation and track the element count it leaves behind
  function automatic void queue_op(rid_func_t f, int pos, logic [VAL_W-1:0] val);
    deque_op_t op;
    op.func     = f;
    op.position = POS_W'(pos);
    op.value    = val;
    pending_ops.push_back(op);
    ops_total++;
    if ((f == FUNC_PUSH_L || f == FUNC_PUSH_R) && gen_count < DEPTH) gen_count++;
    if ((f == FUNC_POP_L || f == FUNC_POP_R) && gen_count > 0) gen_count--;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Mostly in range, sometimes anywhere in the index field
  function automatic int pick_position();
    if (gen_count > 0 && $urandom_range(0, 9) < 8) return $urandom_range(0, gen_count - 1);
    return $urandom_range(0, (1 << POS_W) - 1);
  endfunction

  function automatic void queue_random_op(int push_pct, int pop_pct);
    int        r;
    int        k;
    rid_func_t f;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      f = $urandom_range(0, 1) ? FUNC_PUSH_R : FUNC_PUSH_L;
    end else if (r < push_pct + pop_pct) begin
      f = $urandom_range(0, 1) ? FUNC_POP_R : FUNC_POP_L;
    end else begin
      k = $urandom_range(0, 19);
      if (k < 8) f = FUNC_READ;
      else if (k < 15) f = FUNC_WRITE;
      else if (k < 19) f = FUNC_REVERSE;
      else f = FUNC_NOP;
    end
    queue_op(f, pick_position(), pick_value());
  endfunction

  function automatic int sender_idle_pct();
    case ((ops_accepted / 100) % 4)
      1: return 59;
      3: return 7;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case ((ops_accepted / 100) % 4)
      2: return 59;
      3: return 7;
      default: return 0;
    endcase
  endfunction

  // Drive the input channel and the result ready at the falling edge
  always @(negedge clk) begin : drive
    deque_op_t op;
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          op = pending_ops.pop_front();
          in_valid    <= 1'b1;
          in_func     <= op.func;
          in_position <= op.position;
          in_value    <= op.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !hold_off && ($urandom_range(0, 99) >= receiver_stall_pct());
    end
  end

  // Predict on each accepted transaction, check each delivered result
  always @(posedge clk) begin : observe
    deque_op_t   op;
    deque_view_t want;
    in_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      op.func     = rid_func_t'(in_func);
      op.position = in_position;
      op.value    = in_value;
      due_views.push_back(predict_deque_view(op));
      ops_accepted++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (due_views.size() == 0) begin
        $error("unexpected result transaction: status %0d count %0d", out_status, out_count);
        error_count++;
      end else begin
        want = due_views.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          error_count++;
        end
        if (out_read_data !== want.read_data) begin
          $error("read_data: expected %h, actual %h", want.read_data, out_read_data);
          error_count++;
        end
        if (out_count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, out_count);
          error_count++;
        end
        if (out_is_empty !== want.is_empty) begin
          $error("is_empty: expected %b, actual %b", want.is_empty, out_is_empty);
          error_count++;
        end
        if (out_left_value !== want.left_value) begin
          $error("left_value: expected %h, actual %h", want.left_value, out_left_value);
          error_count++;
        end
        if (out_right_value !== want.right_value) begin
          $error("right_value: expected %h, actual %h", want.right_value, out_right_value);
          error_count++;
        end
      end
    end
  end

  // Hold off the receiver for a long stretch so the block backs up
  initial begin
    wait (ops_accepted >= 400);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  // Bound the run
  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    // Empty deque corner cases
    queue_op(FUNC_POP_L, 0, 32'h0);
    queue_op(FUNC_POP_R, 0, 32'h0);
    queue_op(FUNC_READ, 0, 32'h0);
    queue_op(FUNC_WRITE, 0, 32'h1234_5678);
    queue_op(FUNC_REVERSE, 0, 32'h0);
    queue_op(FUNC_REVERSE, 0, 32'h0);
    // Extreme values at both ends
    queue_op(FUNC_PUSH_L, 0, 32'h7fff_ffff);
    queue_op(FUNC_PUSH_R, 0, 32'h8000_0000);
    queue_op(FUNC_PUSH_L, 0, 32'h0000_0000);
    queue_op(FUNC_PUSH_R, 1023, 32'hffff_ffff);
    queue_op(FUNC_READ, 0, 32'h0);
    queue_op(FUNC_READ, 3, 32'h0);
    queue_op(FUNC_READ, 4, 32'h0);
    queue_op(FUNC_READ, 1023, 32'h0);
    queue_op(FUNC_WRITE, 1, 32'h5555_5555);
    // Indexing and pushes through a reversal
    queue_op(FUNC_REVERSE, 0, 32'h0);
    queue_op(FUNC_READ, 0, 32'h0);
    queue_op(FUNC_WRITE, 0, 32'haaaa_aaaa);
    queue_op(FUNC_PUSH_L, 0, 32'h1234_5678);
    queue_op(FUNC_POP_R, 0, 32'h0);
    queue_op(FUNC_POP_L, 0, 32'h0);
    queue_op(FUNC_NOP, 1023, 32'hffff_ffff);
    queue_op(FUNC_REVERSE, 0, 32'h0);
    queue_op(FUNC_POP_L, 0, 32'h0);
    queue_op(FUNC_POP_R, 0, 32'h0);

    // Small deque, empty often
    repeat (60) queue_random_op(35, 35);
    // Fill to capacity, then push against the full deque
    while (gen_count < DEPTH) queue_random_op(94, 2);
    repeat (15) queue_random_op(70, 0);
    // Shrink again
    repeat (60) queue_random_op(20, 60);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (ops_accepted == ops_total);
    wait (due_views.size() == 0);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
